>>> rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by every module of the block.
package cbm_pkg;

   typedef enum logic [2:0] {
      ST_REG_WRITE = 3'd0,
      ST_ROM_READ  = 3'd1,
      ST_RAM_READ  = 3'd2,
      ST_RAM_WRITE = 3'd3,
      ST_RAM_OFF   = 3'd4,
      ST_INVALID   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_RAM_ENABLE = 2'd0,
      REG_ROM_BANK   = 2'd1,
      REG_UPPER_BANK = 2'd2,
      REG_MODE       = 2'd3
   } reg_sel_type;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int MAP_W    = 21;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic [3:0] ram_enable_nibble;
      logic [4:0] rom_bank_low;
      logic [1:0] upper_bank_bits;
      logic       banking_mode;
   } bank_state_type;

   typedef struct packed {
      logic              write_en;
      reg_sel_type       sel;
      logic [DATA_W-1:0] data;
   } reg_write_type;

   typedef struct packed {
      status_type        status;
      logic [MAP_W-1:0]  mapped_address;
      logic [DATA_W-1:0] ram_write_byte;
   } result_type;

endpackage

>>> rtl/core/cbm_bank_regs.sv
// Control registers of the mapper: RAM enable, ROM bank, upper bank and mode.
// Depends on cbm_pkg.
module cbm_bank_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  cbm_pkg::reg_write_type wr,
   output cbm_pkg::bank_state_type state
);
   import cbm_pkg::*;

   bank_state_type state_ff;
   bank_state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (wr.write_en) begin
         case (wr.sel)
            REG_RAM_ENABLE: state_in.ram_enable_nibble = wr.data[3:0];
            REG_ROM_BANK: begin
               state_in.rom_bank_low = (wr.data[4:0] == 5'd0) ? 5'd1 : wr.data[4:0];
            end
            REG_UPPER_BANK: state_in.upper_bank_bits = wr.data[1:0];
            REG_MODE:       state_in.banking_mode = wr.data[0];
            default:        state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.ram_enable_nibble <= 4'd0;
         state_ff.rom_bank_low      <= 5'd1;
         state_ff.upper_bank_bits   <= 2'd0;
         state_ff.banking_mode      <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

>>> rtl/core/cbm_decode.sv
// Address decode and bank mapping for one bus access.
// Depends on cbm_pkg; purely combinational.
module cbm_decode (
   input  logic                          is_write,
   input  logic [cbm_pkg::ADDR_W-1:0]    bus_address,
   input  logic [cbm_pkg::DATA_W-1:0]    write_data,
   input  cbm_pkg::bank_state_type       state,
   output cbm_pkg::result_type           result,
   output cbm_pkg::reg_write_type        wr
);
   import cbm_pkg::*;

   logic [6:0] rom_bank;
   logic [1:0] ram_bank;

   always_comb begin
      rom_bank = {(state.banking_mode ? 2'd0 : state.upper_bank_bits), state.rom_bank_low};
      ram_bank = state.banking_mode ? state.upper_bank_bits : 2'd0;

      result.status         = ST_INVALID;
      result.mapped_address = '0;
      result.ram_write_byte = '0;
      wr.write_en           = 1'b0;
      wr.sel                = reg_sel_type'(bus_address[14:13]);
      wr.data               = write_data;

      if (!bus_address[15]) begin
         if (is_write) begin
            wr.write_en   = 1'b1;
            result.status = ST_REG_WRITE;
         end else begin
            result.status = ST_ROM_READ;
            if (!bus_address[14]) begin
               result.mapped_address = MAP_W'(bus_address);
            end else begin
               result.mapped_address = {rom_bank, bus_address[13:0]};
            end
         end
      end else if (bus_address[15:13] == 3'b101) begin
         if (state.ram_enable_nibble != RAM_ENABLE_KEY) begin
            result.status = ST_RAM_OFF;
         end else begin
            result.mapped_address = MAP_W'({ram_bank, bus_address[12:0]});
            if (is_write) begin
               result.status         = ST_RAM_WRITE;
               result.ram_write_byte = write_data;
            end else begin
               result.status = ST_RAM_READ;
            end
         end
      end
   end

endmodule

>>> rtl/core/cartridge_bank_mapper_core.sv
// Cartridge bank mapper top level: input register, decode, result register.
// An input transfer is held in the input register, decoded, and held in the result register for the rsp port.
// Throughput: one access per cycle while rsp_tready is high; a stalled result holds a full input register.
// Bank registers update as the access leaves the input register.
// Reset (synchronous, active high) empties both stages and restores the bank defaults.
module cartridge_bank_mapper_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cbm_pkg::REQ_TDATA_W-1:0]    req_tdata,  // bus_address, write_data
   input  logic                               req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cbm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // mapped_address, ram_write_byte, zero pad
   output logic [2:0]                         rsp_tuser   // status
);
   import cbm_pkg::*;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_write_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [DATA_W-1:0]   s1_data_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   result_type          out_ff;
   logic                out_free;
   logic                s1_move;
   logic                req_take;
   bank_state_type      bank_state;
   result_type          dec_result;
   reg_write_type       dec_wr;
   reg_write_type       bank_wr;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_comb begin
      bank_wr          = dec_wr;
      bank_wr.write_en = dec_wr.write_en && s1_move;
   end

   cbm_decode u_decode (
      .is_write    (s1_write_ff),
      .bus_address (s1_addr_ff),
      .write_data  (s1_data_ff),
      .state       (bank_state),
      .result      (dec_result),
      .wr          (dec_wr)
   );

   cbm_bank_regs u_bank_regs (
      .clock (clock),
      .reset (reset),
      .wr    (bank_wr),
      .state (bank_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_write_ff <= req_tuser;
         s1_addr_ff  <= req_tdata[ADDR_W-1:0];
         s1_data_ff  <= req_tdata[ADDR_W +: DATA_W];
      end
      if (s1_move) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {3'd0, out_ff.ram_write_byte, out_ff.mapped_address};

endmodule

>>> rtl/core/cbm_checker.sv
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg and cartridge_bank_mapper_core.
module cbm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]                      rsp_tuser
);
   import cbm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_REG_WRITE || rsp_tuser == ST_RAM_OFF ||
                     rsp_tuser == ST_INVALID) |-> rsp_tdata == '0)
      else $error("non-memory status carries an address or byte");

   a_byte_only_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_RAM_WRITE |-> rsp_tdata[28:21] == 8'd0)
      else $error("RAM byte set on a transfer that is not a RAM write");

   a_ram_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_RAM_READ || rsp_tuser == ST_RAM_WRITE)
      |-> rsp_tdata[20:15] == 6'd0)
      else $error("RAM address beyond four 8 KiB banks");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (.*);

>>> tb/sv/cartridge_bank_mapper_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_mapper_core: directed and random bus accesses
// are checked against a bank-register predictor under several idle and stall patterns.
// Depends on cbm_pkg and the cartridge_bank_mapper_core RTL only.
module cartridge_bank_mapper_core_tb;
   import cbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;

   bank_state_type banks;
   result_type     expected_results[$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;

   cartridge_bank_mapper_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic map_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, output result_type r);
      logic [6:0] bank;
      r.status = ST_INVALID;
      r.mapped_address = '0;
      r.ram_write_byte = '0;
      if (!addr[15]) begin
         if (wr) begin
            r.status = ST_REG_WRITE;
            case (reg_sel_type'(addr[14:13]))
               REG_RAM_ENABLE: banks.ram_enable_nibble = data[3:0];
               REG_ROM_BANK:   banks.rom_bank_low = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
               REG_UPPER_BANK: banks.upper_bank_bits = data[1:0];
               REG_MODE:       banks.banking_mode = data[0];
               default:        banks = banks;
            endcase
         end else if (!addr[14]) begin
            r.status = ST_ROM_READ;
            r.mapped_address = {5'd0, addr};
         end else begin
            bank = banks.banking_mode ? {2'b00, banks.rom_bank_low}
                                      : {banks.upper_bank_bits, banks.rom_bank_low};
            r.status = ST_ROM_READ;
            r.mapped_address = {bank, addr[13:0]};
         end
      end else if (addr[15:13] == 3'b101) begin
         if (banks.ram_enable_nibble != RAM_ENABLE_KEY) begin
            r.status = ST_RAM_OFF;
         end else begin
            r.status = wr ? ST_RAM_WRITE : ST_RAM_READ;
            r.mapped_address = {6'd0, banks.banking_mode ? banks.upper_bank_bits : 2'b00,
                                addr[12:0]};
            r.ram_write_byte = wr ? data : '0;
         end
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {data, addr};
      req_tuser = wr;
      do @(posedge clock); while (!req_tready);
      map_access(wr, addr, data, r);
      expected_results.push_back(r);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result: actual status %0d addr %h byte %h", $time,
                     rsp_tuser, rsp_tdata[20:0], rsp_tdata[28:21]);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser != want.status) begin
               $display("%0t status: expected %0d actual %0d", $time, want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[20:0] != want.mapped_address) begin
               $display("%0t mapped_address: expected %h actual %h", $time,
                        want.mapped_address, rsp_tdata[20:0]);
               mismatch_count++;
            end
            if (rsp_tdata[28:21] != want.ram_write_byte) begin
               $display("%0t ram_write_byte: expected %h actual %h", $time,
                        want.ram_write_byte, rsp_tdata[28:21]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired with %0d results outstanding", $time,
                  expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b0, 16'h7FFF, 8'hFF);
      send_access(1'b0, 16'hA000, 8'h00);
      send_access(1'b1, 16'hBFFF, 8'hFF);
   endtask

   task automatic test_rom_banking();
      send_access(1'b1, 16'h2000, 8'h00);
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b1, 16'h3FFF, 8'hFF);
      send_access(1'b1, 16'h4000, 8'hFF);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b1, 16'h6000, 8'h01);
      send_access(1'b0, 16'h4000, 8'hFF);
      send_access(1'b0, 16'h0000, 8'h00);
      send_access(1'b0, 16'h3FFF, 8'h00);
   endtask

   task automatic test_ram_access();
      send_access(1'b1, 16'h1FFF, 8'h0A);
      send_access(1'b1, 16'hA000, 8'hFF);
      send_access(1'b0, 16'hBFFF, 8'h00);
      send_access(1'b1, 16'h7FFF, 8'h00);
      send_access(1'b0, 16'hBFFF, 8'h00);
      send_access(1'b1, 16'h0000, 8'hF0);
      send_access(1'b1, 16'hA000, 8'h5A);
   endtask

   task automatic test_invalid_addresses();
      send_access(1'b0, 16'h8000, 8'h00);
      send_access(1'b1, 16'h9FFF, 8'hFF);
      send_access(1'b0, 16'hC000, 8'h00);
      send_access(1'b1, 16'hFFFF, 8'h55);
   endtask

   // A random mix of register writes, ROM reads and RAM accesses, with some raw noise.
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int                  pick;
      logic [1:0]          sel;
      logic [DATA_W-1:0]   data;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         data = $urandom_range(255);
         if (pick < 30) begin
            sel = $urandom_range(3);
            if (sel == REG_RAM_ENABLE && $urandom_range(1))
               data[3:0] = RAM_ENABLE_KEY;
            if (sel == REG_ROM_BANK && $urandom_range(9) == 0)
               data[4:0] = 5'd0;
            send_access(1'b1, {1'b0, sel, 13'($urandom_range(8191))}, data);
         end else if (pick < 55) begin
            send_access(1'b0, 16'($urandom_range(16'h7FFF)), data);
         end else if (pick < 85) begin
            send_access(1'($urandom_range(1)), {3'b101, 13'($urandom_range(8191))}, data);
         end else begin
            send_access(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)), data);
         end
      end
   endtask

   task automatic test_drain_and_report();
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   endtask

   initial begin
      banks.ram_enable_nibble = 4'd0;
      banks.rom_bank_low = 5'd1;
      banks.upper_bank_bits = 2'd0;
      banks.banking_mode = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_rom_banking();
      test_ram_access();
      test_invalid_addresses();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 80, 0);
      test_random_traffic(400, 0, 80);
      test_random_traffic(400, 27, 27);
      test_drain_and_report();
   end

endmodule
